/* src/sbmq_pkg.sv */
// Package for the shared-buffer multi-queue: status codes, action codes,
// controller states and the memory write-enable bundle. No dependencies.
`default_nettype none

package sbmq_pkg;

  localparam int unsigned DataW = 32;

  // Action field codes
  localparam logic ACT_ENQ = 1'b0;
  localparam logic ACT_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_COMMIT
  } state_e;

  // Write enables from the controller to the two slot RAMs
  typedef struct packed {
    logic link_we;
    logic data_we;
  } mem_wr_t;

endpackage

`default_nettype wire

/* src/sbmq_ram.sv */
// Simple dual-port synchronous RAM: one write port, one read port,
// registered read data. Uses no package.
`default_nettype none

module sbmq_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

/* src/sbmq_ctrl.sv */
// Controller for the shared-buffer multi-queue: command sequencer, queue
// head/tail table, free-list head and fresh-slot count. Uses sbmq_pkg.
`default_nettype none

module sbmq_ctrl #(
  parameter int unsigned SLOTS  = 16,
  parameter int unsigned QUEUES = 4
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic                        action_i,
  input  wire logic [1:0]                  queue_id_i,
  input  wire logic signed [31:0]          data_in_i,
  output logic                             busy_o,
  output logic                             done_o,
  output logic [1:0]                       status_o,
  output logic signed [31:0]               data_out_o,
  output sbmq_pkg::mem_wr_t                wr_o,
  output logic [$clog2(SLOTS)-1:0]         link_raddr_o,
  input  wire logic [$clog2(SLOTS):0]      link_rdata_i,
  output logic [$clog2(SLOTS)-1:0]         link_waddr_o,
  output logic [$clog2(SLOTS):0]           link_wdata_o,
  output logic [$clog2(SLOTS)-1:0]         data_raddr_o,
  input  wire logic [sbmq_pkg::DataW-1:0]  data_rdata_i,
  output logic [$clog2(SLOTS)-1:0]         data_waddr_o,
  output logic [sbmq_pkg::DataW-1:0]       data_wdata_o
);

  import sbmq_pkg::*;

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;

  // Pointers are {valid, index}
  state_e              state_q, state_d;
  logic                act_q;
  logic [QW-1:0]       q_q;
  logic [DataW-1:0]    data_q;
  logic [IW:0]         fh_q, fh_d;
  logic [IW:0]         fresh_q, fresh_d;
  logic [IW-1:0]       slot_q, slot_d;
  logic                link_q, link_d;
  logic [QUEUES-1:0]   hv_q;
  logic                hv_we, hv_wval;
  logic [2*IW-1:0]     qmem [QUEUES];
  logic [2*IW-1:0]     qrd_q;
  logic                qwe;
  logic [2*IW-1:0]     qwdata;
  status_e             status_q, status_d;
  logic [DataW-1:0]    dout_q, dout_d;
  logic                done_q, done_d;
  logic [QW-1:0]       qsel;
  logic [6:0]          qv;
  logic                accept;
  logic [IW-1:0]       qhead, qtail, s_free;
  logic [IW:0]         s_next;

  assign accept = start_i && (state_q == S_IDLE);
  assign qhead  = qrd_q[2*IW-1:IW];
  assign qtail  = qrd_q[IW-1:0];
  assign s_free = fh_q[IW-1:0];
  assign s_next = {1'b0, s_free} + 1'b1;

  // Reduce the queue number below QUEUES
  always_comb begin
    qv = {5'b0, queue_id_i};
    for (int i = 0; i < 3; i++) begin
      if (qv >= 7'(QUEUES)) begin
        qv = qv - 7'(QUEUES);
      end
    end
    qsel = qv[QW-1:0];
  end

  // Queue head/tail table: read while idle, written by the sequencer
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE) begin
      qrd_q <= qmem[qsel];
    end
    if (qwe) begin
      qmem[q_q] <= qwdata;
    end
  end

  // Command word capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q  <= action_i;
      q_q    <= qsel;
      data_q <= data_in_i;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      fh_q     <= {1'b1, {IW{1'b0}}};
      fresh_q  <= '0;
      hv_q     <= '0;
      done_q   <= 1'b0;
      status_q <= ST_OK;
      dout_q   <= '0;
      slot_q   <= '0;
      link_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      fh_q     <= fh_d;
      fresh_q  <= fresh_d;
      done_q   <= done_d;
      status_q <= status_d;
      dout_q   <= dout_d;
      slot_q   <= slot_d;
      link_q   <= link_d;
      if (hv_we) begin
        hv_q[q_q] <= hv_wval;
      end
    end
  end

  // Next state, list updates and RAM controls
  always_comb begin
    state_d      = state_q;
    fh_d         = fh_q;
    fresh_d      = fresh_q;
    slot_d       = slot_q;
    link_d       = link_q;
    status_d     = status_q;
    dout_d       = dout_q;
    done_d       = 1'b0;
    hv_we        = 1'b0;
    hv_wval      = 1'b0;
    qwe          = 1'b0;
    qwdata       = qrd_q;
    wr_o         = '0;
    link_waddr_o = slot_q;
    link_wdata_o = '0;
    link_raddr_o = (state_q == S_IDLE) ? s_free : qhead;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        state_d = S_COMMIT;
        dout_d  = '0;
        if (act_q == ACT_ENQ) begin
          if (!fh_q[IW]) begin
            status_d = ST_OVERFLOW;
          end else begin
            status_d = ST_OK;
            slot_d   = s_free;
            link_d   = hv_q[q_q];
            // Advance the free list; a never-used slot links to the one after it
            if ({1'b0, s_free} >= fresh_q) begin
              fresh_d = fresh_q + 1'b1;
              fh_d    = (s_next < (IW+1)'(SLOTS)) ? {1'b1, s_next[IW-1:0]} : '0;
            end else begin
              fh_d = link_rdata_i;
            end
            // Terminate the new slot and store its word
            wr_o.link_we = 1'b1;
            wr_o.data_we = 1'b1;
            link_waddr_o = s_free;
            link_wdata_o = '0;
            qwe          = 1'b1;
            qwdata       = hv_q[q_q] ? {qhead, s_free} : {s_free, s_free};
            hv_we        = 1'b1;
            hv_wval      = 1'b1;
          end
        end else begin
          if (!hv_q[q_q]) begin
            status_d = ST_UNDERFLOW;
          end else begin
            status_d = ST_OK;
            slot_d   = qhead;
          end
        end
      end
      S_COMMIT: begin
        state_d = S_IDLE;
        done_d  = 1'b1;
        if (status_q == ST_OK) begin
          if (act_q == ACT_ENQ) begin
            // Link the old tail to the new slot
            if (link_q) begin
              wr_o.link_we = 1'b1;
              link_waddr_o = qtail;
              link_wdata_o = {1'b1, slot_q};
            end
          end else begin
            // Unlink the head and push its slot onto the free list
            dout_d       = data_rdata_i;
            qwe          = 1'b1;
            qwdata       = {link_rdata_i[IW-1:0], qtail};
            hv_we        = 1'b1;
            hv_wval      = link_rdata_i[IW];
            wr_o.link_we = 1'b1;
            link_waddr_o = slot_q;
            link_wdata_o = fh_q;
            fh_d         = {1'b1, slot_q};
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign data_raddr_o = qhead;
  assign data_waddr_o = s_free;
  assign data_wdata_o = data_q;

  assign busy_o     = (state_q != S_IDLE);
  assign done_o     = done_q;
  assign status_o   = status_q;
  assign data_out_o = dout_q;

endmodule

`default_nettype wire

/* src/shared_buffer_multi_queue.sv */
// Top level of the shared-buffer multi-queue: controller plus the slot
// next-pointer RAM and slot data RAM. Uses sbmq_pkg, sbmq_ctrl, sbmq_ram.
//
//  channel  | handshake         | fields
//  ---------+-------------------+------------------------------------
//  command  | start / busy      | action_i, queue_id_i, data_in_i
//  result   | done_o (strobe)   | status_o, data_out_o
//
// A command is taken at an edge with start high and busy low. The controller
// then steps through its look and commit states; the result shows for one
// cycle on done_o and busy drops in that cycle, so no new command is taken
// before the last one completes. The pace is set by the next-pointer RAM:
// read the link, then write one or two links.
// After reset no clearing pass runs: a fresh-slot count stands in for the
// initial free-list chain. The result side cannot stall.
`default_nettype none

module shared_buffer_multi_queue #(
  parameter int unsigned SLOTS  = 16,
  parameter int unsigned QUEUES = 4
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               action_i,
  input  wire logic [1:0]         queue_id_i,
  input  wire logic signed [31:0] data_in_i,
  output logic                    done_o,
  output logic [1:0]              status_o,
  output logic signed [31:0]      data_out_o
);

  import sbmq_pkg::*;

  localparam int unsigned IW = $clog2(SLOTS);

  mem_wr_t           wr;
  logic [IW-1:0]     link_raddr, link_waddr, data_raddr, data_waddr;
  logic [IW:0]       link_rdata, link_wdata;
  logic [DataW-1:0]  data_rdata, data_wdata;

  // Sequencer and queue table
  sbmq_ctrl #(
    .SLOTS  (SLOTS),
    .QUEUES (QUEUES)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .action_i     (action_i),
    .queue_id_i   (queue_id_i),
    .data_in_i    (data_in_i),
    .busy_o       (busy),
    .done_o       (done_o),
    .status_o     (status_o),
    .data_out_o   (data_out_o),
    .wr_o         (wr),
    .link_raddr_o (link_raddr),
    .link_rdata_i (link_rdata),
    .link_waddr_o (link_waddr),
    .link_wdata_o (link_wdata),
    .data_raddr_o (data_raddr),
    .data_rdata_i (data_rdata),
    .data_waddr_o (data_waddr),
    .data_wdata_o (data_wdata)
  );

  // Next pointer per slot
  sbmq_ram #(
    .DEPTH (SLOTS),
    .WIDTH (IW + 1)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (wr.link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (link_raddr),
    .rdata_o (link_rdata)
  );

  // Data word per slot
  sbmq_ram #(
    .DEPTH (SLOTS),
    .WIDTH (DataW)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (wr.data_we),
    .waddr_i (data_waddr),
    .wdata_i (data_wdata),
    .raddr_i (data_raddr),
    .rdata_o (data_rdata)
  );

`ifndef NO_ASSERTIONS
  // Every accepted command is followed by a result strobe
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##3 done_o)
    else $error("result strobe missing three cycles after accept");

  // A result only follows a busy period
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result strobe without a command in flight");

  // Failed commands return a zero word
  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |-> (data_out_o == '0))
    else $error("nonzero data on overflow or underflow");

  // Accepting a command raises busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");
`endif

endmodule

`default_nettype wire

/* tb/tb_shared_buffer_multi_queue.sv */
// Testbench for shared_buffer_multi_queue: directed and random enqueue/dequeue
// words checked against a linked-slot predictor held in a scoreboard class.
// Depends on sbmq_pkg and the shared_buffer_multi_queue RTL.
`timescale 1ns / 1ps

module tb_shared_buffer_multi_queue;
  import sbmq_pkg::*;

  localparam int unsigned SLOTS      = 16;
  localparam int unsigned QUEUES     = 4;
  localparam int unsigned IDX_W      = $clog2(SLOTS);
  localparam int unsigned RAND_WORDS = 642;
  localparam int unsigned SETTLE     = 8;

  // Slot pointer with its own valid bit
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
  } link_t;

  typedef struct {
    status_e            st;
    logic signed [31:0] val;
  } outcome_t;

  // Scoreboard: mirrors the shared slot store and checks each result word
  class slot_store_scoreboard;
    logic signed [31:0] slot_val [SLOTS];
    link_t              slot_link[SLOTS];
    link_t              first    [QUEUES];
    link_t              last     [QUEUES];
    link_t              free_top;
    outcome_t           awaited[$];
    int                 errors;
    int                 checked;
    int                 n_enq;
    int                 n_deq;
    int                 n_full;
    int                 n_empty;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        slot_val[i]  = '0;
        slot_link[i] = (i + 1 < SLOTS) ? link_t'{1'b1, IDX_W'(i + 1)} : link_t'('0);
      end
      for (int i = 0; i < QUEUES; i++) begin
        first[i] = '0;
        last[i]  = '0;
      end
      free_top = link_t'{1'b1, '0};
      errors   = 0;
      checked  = 0;
      n_enq    = 0;
      n_deq    = 0;
      n_full   = 0;
      n_empty  = 0;
    endfunction

    // Advance the slot store by one accepted word and queue its outcome
    function void note_command(logic act, logic [1:0] qid, logic signed [31:0] din);
      outcome_t         res;
      int unsigned      q;
      logic [IDX_W-1:0] s;
      q       = qid % QUEUES;
      res.st  = ST_OK;
      res.val = '0;
      if (act == ACT_ENQ) begin
        n_enq++;
        if (!free_top.valid) begin
          res.st = ST_OVERFLOW;
          n_full++;
        end else begin
          s        = free_top.idx;
          free_top = slot_link[s];
          // link after the tail, or start the chain when the queue is empty
          if (!first[q].valid) first[q] = link_t'{1'b1, s};
          else if (last[q].valid) slot_link[last[q].idx] = link_t'{1'b1, s};
          slot_link[s] = '0;
          last[q]      = link_t'{1'b1, s};
          slot_val[s]  = din;
        end
      end else begin
        n_deq++;
        if (!first[q].valid) begin
          res.st = ST_UNDERFLOW;
          n_empty++;
        end else begin
          // unlink the head slot and push it onto the free chain
          s            = first[q].idx;
          res.val      = slot_val[s];
          first[q]     = slot_link[s];
          slot_link[s] = free_top;
          free_top     = link_t'{1'b1, s};
        end
      end
      awaited.push_back(res);
    endfunction

    // Compare one result word with the oldest outcome
    function void check_result(logic [1:0] st, logic signed [31:0] dout);
      outcome_t res;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result word status=%0d data=%0h", $time, st, dout);
        errors++;
        return;
      end
      res = awaited.pop_front();
      checked++;
      if (st !== res.st) begin
        $display("%0t: status mismatch expected=%0d actual=%0d", $time, res.st, st);
        errors++;
      end
      if (dout !== res.val) begin
        $display("%0t: data mismatch expected=%0h actual=%0h", $time, res.val, dout);
        errors++;
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic               action_i;
  logic [1:0]         queue_id_i;
  logic signed [31:0] data_in_i;
  logic               done_o;
  logic [1:0]         status_o;
  logic signed [31:0] data_out_o;

  slot_store_scoreboard sb = new();

  shared_buffer_multi_queue #(
    .SLOTS (SLOTS),
    .QUEUES(QUEUES)
  ) uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .action_i  (action_i),
    .queue_id_i(queue_id_i),
    .data_in_i (data_in_i),
    .done_o    (done_o),
    .status_o  (status_o),
    .data_out_o(data_out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Check every result strobe
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(status_o, data_out_o);
  end

  // Present one word and hold it until the block takes it
  task automatic send_word(input logic act, input logic [1:0] qid,
                           input logic signed [31:0] din);
    @(negedge clk_i);
    start      <= 1'b1;
    action_i   <= act;
    queue_id_i <= qid;
    data_in_i  <= din;
    do @(posedge clk_i); while (busy);
    sb.note_command(act, qid, din);
  endtask

  // Drop start for a number of cycles
  task automatic idle_for(input int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
  endtask

  // Hold off the sender until every result word has come back
  task automatic wait_drain();
    idle_for(1);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  initial begin
    logic               act;
    logic [1:0]         qid;
    logic signed [31:0] din;
    bit                 fill_bias;
    int unsigned        idle_pct;

    rst_ni     = 1'b0;
    start      = 1'b0;
    action_i   = ACT_ENQ;
    queue_id_i = '0;
    data_in_i  = '0;
    fill_bias  = 1'b1;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty dequeue, fill every slot, overflow, drain one queue,
    // then refill it through its stale tail
    send_word(ACT_DEQ, 2'd0, 32'sd0);
    for (int i = 0; i < SLOTS; i++) begin
      case (i)
        0:       din = 32'sh8000_0000;
        1:       din = 32'sh7fff_ffff;
        2:       din = 32'sd0;
        3:       din = -32'sd1;
        default: din = $urandom;
      endcase
      send_word(ACT_ENQ, (i < 4) ? 2'd3 : 2'(i % 3), din);
    end
    send_word(ACT_ENQ, 2'd2, 32'sh5555_aaaa);
    repeat (4) send_word(ACT_DEQ, 2'd3, $urandom);
    send_word(ACT_DEQ, 2'd3, 32'sd0);
    send_word(ACT_ENQ, 2'd3, 32'shaaaa_5555);
    send_word(ACT_DEQ, 2'd3, 32'sd0);
    wait_drain();

    // Random: runs that lean toward filling or draining, three idle profiles
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 24 : (phase == 1) ? 61 : 0;
      repeat (RAND_WORDS) begin
        if ($urandom_range(0, 29) == 0) fill_bias = !fill_bias;
        act = ($urandom_range(0, 99) < (fill_bias ? 72 : 28)) ? ACT_ENQ : ACT_DEQ;
        qid = $urandom_range(0, 3);
        case ($urandom_range(0, 9))
          0:       din = 32'sh8000_0000;
          1:       din = 32'sh7fff_ffff;
          2:       din = -32'sd1;
          3:       din = 32'sd0;
          default: din = $urandom;
        endcase
        send_word(act, qid, din);
        if ($urandom_range(0, 99) < idle_pct) idle_for($urandom_range(1, 4));
      end
      wait_drain();
    end

    $display("Checked %0d result words: %0d enqueues (%0d overflow), %0d dequeues (%0d underflow).",
             sb.checked, sb.n_enq, sb.n_full, sb.n_deq, sb.n_empty);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog against a hung handshake
  initial begin
    #5ms;
    $display("%0t: timeout with %0d result words outstanding", $time, sb.pending());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
